/* rtl/cle_pkg.sv */
package cle_pkg;

  localparam int OpcodeW  = 3;
  localparam int SlotW    = 5;
  localparam int ValueW   = 32;
  localparam int StatusW  = 2;
  localparam int PairW    = 4;
  localparam int MaskW    = 5;
  localparam int MapW     = 6;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  localparam logic [OpcodeW-1:0] OP_SET_COUNT = 3'd0;
  localparam logic [OpcodeW-1:0] OP_EVALUATE  = 3'd1;
  localparam logic [OpcodeW-1:0] OP_TRIGGER   = 3'd2;
  localparam logic [OpcodeW-1:0] OP_LIMIT     = 3'd3;
  localparam logic [OpcodeW-1:0] OP_DELTA     = 3'd4;
  localparam logic [OpcodeW-1:0] OP_MAP       = 3'd5;
  localparam logic [OpcodeW-1:0] OP_READ_SRC  = 3'd6;

  localparam logic [StatusW-1:0] STS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STS_SLOT  = 2'd1;
  localparam logic [StatusW-1:0] STS_VALUE = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_EVENTS_ENABLED  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COUNTERS_IN_USE = 1'b1;

  localparam logic [ValueW-1:0]   TRIG_MAX       = 32'h0000_001F;
  localparam logic [MaskW-1:0]    TRIG_RESET     = 5'h07;
  localparam int                  TRIG_LIMIT_POS = 0;
  localparam int                  TRIG_DELTA_POS = 1;
  localparam logic [CfgDataW-1:0] CNT_IN_USE_RST = 6'd32;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [SlotW-1:0]   slot;
    logic [ValueW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               event_fired;
    logic [SlotW-1:0]   fired_counter;
    logic [PairW-1:0]   pdo_pair;
    logic [ValueW-1:0]  read_data;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

/* rtl/cle_ctrl.sv */
module cle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cle_pkg::dp_cmd_t  cmd_o
);
  import cle_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  dp_cmd_t    cmd;

  always_comb begin
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    state_d   = state_q;
    out_vld_d = out_vld_q & out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_vld_q || !out_stall_i) begin
          cmd.exec  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign cmd_o       = cmd;

endmodule

/* rtl/cle_datapath.sv */
module cle_datapath #(
  parameter int NUM_COUNTERS = 32,
  parameter int NUM_LOGICAL  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cle_pkg::dp_cmd_t              cmd_i,
  input  logic                          cfg_we_i,
  input  logic [cle_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cle_pkg::CfgDataW-1:0]  cfg_data_i,
  input  cle_pkg::in_item_t             in_data_i,
  output cle_pkg::out_item_t            out_data_o
);
  import cle_pkg::*;

  localparam int CW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int LW = (NUM_LOGICAL > 1) ? $clog2(NUM_LOGICAL) : 1;
  localparam logic [MapW-1:0] NC = MapW'(NUM_COUNTERS);
  localparam logic [MapW-1:0] NL = MapW'(NUM_LOGICAL);

  // counter memories
  logic [ValueW-1:0] cnt_mem [NUM_COUNTERS];
  logic [ValueW-1:0] rep_mem [NUM_COUNTERS];
  logic [ValueW-1:0] lim_mem [NUM_COUNTERS];
  logic [ValueW-1:0] dlt_mem [NUM_COUNTERS];
  logic [MaskW-1:0]  msk_mem [NUM_COUNTERS];

  logic [NUM_COUNTERS-1:0] cnt_vld_q, rep_vld_q, lim_vld_q, dlt_vld_q, msk_vld_q;
  logic [MapW-1:0]         map_q [NUM_LOGICAL];
  logic [ValueW-1:0]       src_q;
  logic                    en_q;
  logic [CfgDataW-1:0]     in_use_q;

  logic [OpcodeW-1:0] op_q;
  logic [SlotW-1:0]   slot_q;
  logic [ValueW-1:0]  val_q;
  logic [CW-1:0]      ch_q;
  logic               map_ok_q;
  logic [ValueW-1:0]  cnt_rd_q, rep_rd_q, lim_rd_q, dlt_rd_q;
  logic [MaskW-1:0]   msk_rd_q;
  out_item_t          out_q;

  // load-side lookup
  logic [MapW-1:0] map_ent, ch_full;
  logic            map_ok;

  always_comb begin
    map_ent = map_q[in_data_i.slot[LW-1:0]];
    ch_full = map_ent - MapW'(1);
    map_ok  = ({1'b0, in_data_i.slot} < NL) && (map_ent != '0) && (map_ent <= NC);
  end

  // execute-side evaluation
  logic [MapW-1:0]   slot6, present;
  logic [ValueW-1:0] c, p, lim, dlt, diff;
  logic [MaskW-1:0]  msk;
  logic              fire;
  logic              cnt_we, rep_we, msk_we, lim_we, dlt_we, map_we, src_clr;
  out_item_t         res;

  always_comb begin
    slot6   = {1'b0, slot_q};
    present = (in_use_q > NC) ? NC : in_use_q;
    c       = cnt_vld_q[ch_q] ? cnt_rd_q : '0;
    p       = rep_vld_q[ch_q] ? rep_rd_q : '0;
    lim     = lim_vld_q[ch_q] ? lim_rd_q : '0;
    dlt     = dlt_vld_q[ch_q] ? dlt_rd_q : '0;
    msk     = msk_vld_q[ch_q] ? msk_rd_q : TRIG_RESET;
    diff    = (c >= p) ? (c - p) : (p - c);
    fire    = map_ok_q && en_q && (c != p) && (c >= lim) && msk[TRIG_LIMIT_POS]
              && (!msk[TRIG_DELTA_POS] || (diff >= dlt));

    cnt_we  = 1'b0;
    rep_we  = 1'b0;
    msk_we  = 1'b0;
    lim_we  = 1'b0;
    dlt_we  = 1'b0;
    map_we  = 1'b0;
    src_clr = 1'b0;
    res     = '0;
    case (op_q)
      OP_SET_COUNT: begin
        if (slot6 >= NC) res.status = STS_SLOT;
        else cnt_we = 1'b1;
      end
      OP_EVALUATE: begin
        if (slot6 >= NL) begin
          res.status = STS_SLOT;
        end else if (fire) begin
          rep_we            = 1'b1;
          res.event_fired   = 1'b1;
          res.fired_counter = SlotW'(ch_q);
          res.pdo_pair      = slot_q[SlotW-1:1];
        end
      end
      OP_TRIGGER, OP_LIMIT, OP_DELTA: begin
        if (slot6 >= present) begin
          res.status = STS_SLOT;
        end else if (op_q == OP_TRIGGER) begin
          if (val_q > TRIG_MAX) res.status = STS_VALUE;
          else msk_we = 1'b1;
        end else if (op_q == OP_LIMIT) begin
          lim_we = 1'b1;
        end else begin
          dlt_we = 1'b1;
        end
      end
      OP_MAP: begin
        if (slot6 >= NL) res.status = STS_SLOT;
        else if (val_q == '0 || val_q > {{(ValueW-MapW){1'b0}}, present})
          res.status = STS_VALUE;
        else map_we = 1'b1;
      end
      OP_READ_SRC: begin
        res.read_data = src_q;
        src_clr       = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_data_i.opcode;
      slot_q   <= in_data_i.slot;
      val_q    <= in_data_i.value;
      ch_q     <= ch_full[CW-1:0];
      map_ok_q <= map_ok;
      cnt_rd_q <= cnt_mem[ch_full[CW-1:0]];
      rep_rd_q <= rep_mem[ch_full[CW-1:0]];
      lim_rd_q <= lim_mem[ch_full[CW-1:0]];
      dlt_rd_q <= dlt_mem[ch_full[CW-1:0]];
      msk_rd_q <= msk_mem[ch_full[CW-1:0]];
    end
    if (cmd_i.exec) begin
      out_q <= res;
      if (cnt_we) cnt_mem[slot_q[CW-1:0]] <= val_q;
      if (rep_we) rep_mem[ch_q] <= c;
      if (lim_we) lim_mem[slot_q[CW-1:0]] <= val_q;
      if (dlt_we) dlt_mem[slot_q[CW-1:0]] <= val_q;
      if (msk_we) msk_mem[slot_q[CW-1:0]] <= val_q[MaskW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rep_vld_q <= '0;
      lim_vld_q <= '0;
      dlt_vld_q <= '0;
      msk_vld_q <= '0;
      src_q     <= '0;
      en_q      <= 1'b0;
      in_use_q  <= CNT_IN_USE_RST;
      for (int i = 0; i < NUM_LOGICAL; i++) begin
        map_q[i] <= MapW'(i + 1);
      end
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_EVENTS_ENABLED) en_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == CFG_COUNTERS_IN_USE) in_use_q <= cfg_data_i;
      if (cmd_i.exec) begin
        if (cnt_we) cnt_vld_q[slot_q[CW-1:0]] <= 1'b1;
        if (lim_we) lim_vld_q[slot_q[CW-1:0]] <= 1'b1;
        if (dlt_we) dlt_vld_q[slot_q[CW-1:0]] <= 1'b1;
        if (msk_we) msk_vld_q[slot_q[CW-1:0]] <= 1'b1;
        if (rep_we) begin
          rep_vld_q[ch_q] <= 1'b1;
          src_q           <= src_q | (ValueW'(1) << ch_q);
        end
        if (src_clr) src_q <= '0;
        if (map_we) map_q[slot_q[LW-1:0]] <= val_q[MapW-1:0];
      end
    end
  end

  assign out_data_o = out_q;

endmodule

/* rtl/counter_limit_delta_event_unit.sv */
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  in_data_i   (opcode, slot, value)
// out      output     out_valid_o / out_stall_i out_data_o (status, event, counter, pair, data)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item is first loaded, reading the counter memories, then executed,
// evaluating and writing back once the output register can take the result.
// A new item is taken while a finished result waits in the output register.
// Execution holds while the output register is full and stalled.
// Reset is asynchronous; per-entry valid bits give reset values, no clear pass.
module counter_limit_delta_event_unit #(
  parameter int NUM_COUNTERS = 32,
  parameter int NUM_LOGICAL  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cle_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cle_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cle_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cle_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cle_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  cle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  cle_datapath #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .NUM_LOGICAL  (NUM_LOGICAL)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o)
  );

  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_valid_o)
    else $error("result missing after execute");

  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.event_fired) |->
      (out_data_o.status == STS_OK && out_data_o.read_data == '0))
    else $error("event result with bad status or data");

endmodule
